[design/euclid_gcd_core_assert.svh]
// assertion macros for the gcd core
// used by euclid_gcd_core; expects clk and arst_n in scope
`ifndef EUCLID_GCD_CORE_ASSERT_SVH
`define EUCLID_GCD_CORE_ASSERT_SVH
`ifndef SYNTH
`define EGCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define EGCD_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define EGCD_ASSERT(label, prop, msg)
`define EGCD_ASSERT_NEVER(label, expr, msg)
`endif
`endif

[design/egcd_pkg.sv]
// shared types for the gcd core
// control and status groups between sequencer and datapath
package egcd_pkg;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} egcd_cmd_t;

	typedef struct packed {
		logic done;
	} egcd_stat_t;

endpackage

[design/egcd_datapath.sv]
// operand registers and the shared subtract/shift unit of the gcd core
// depends on egcd_pkg
module egcd_datapath
	import egcd_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic signed [DATA_WIDTH-1:0] first_value,
	input  logic signed [DATA_WIDTH-1:0] second_value,
	input  egcd_cmd_t                    cmd,
	output egcd_stat_t                   stat,
	output logic        [DATA_WIDTH-1:0] result
);

	localparam int KW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	logic [DATA_WIDTH-1:0] u_q;
	logic [DATA_WIDTH-1:0] v_q;
	logic [KW-1:0]         k_q;
	logic [DATA_WIDTH-1:0] a_raw;
	logic [DATA_WIDTH-1:0] b_raw;
	logic [DATA_WIDTH-1:0] a_mag;
	logic [DATA_WIDTH-1:0] b_mag;
	logic [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH-1:0] diff_neg;

	assign a_raw = first_value;
	assign b_raw = second_value;
	assign a_mag = a_raw[DATA_WIDTH-1] ? (~a_raw + 1'b1) : a_raw;
	assign b_mag = b_raw[DATA_WIDTH-1] ? (~b_raw + 1'b1) : b_raw;

	// shared subtractor, borrow picks which operand is replaced
	assign diff     = {1'b0, u_q} - {1'b0, v_q};
	assign diff_neg = ~diff[DATA_WIDTH-1:0] + 1'b1;

	assign stat.done = (u_q == '0) || (v_q == '0);
	assign result    = (u_q | v_q) << k_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u_q <= a_mag;
			v_q <= b_mag;
			k_q <= '0;
		end else if (cmd.step) begin
			priority if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (diff[DATA_WIDTH]) begin
				v_q <= diff_neg;
			end else begin
				u_q <= diff[DATA_WIDTH-1:0];
			end
		end
	end

endmodule

[design/egcd_ctrl.sv]
// sequencer of the gcd core: load, iterate, hand off to the result register
// depends on egcd_pkg
module egcd_ctrl
	import egcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_valid,
	output logic       op_ready,
	input  logic       slot_free,
	input  egcd_stat_t stat,
	output egcd_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} egcd_state_t;

	egcd_state_t state_q;
	egcd_state_t state_d;

	assign op_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!stat.done) begin
					cmd.step = 1'b1;
				end else if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/euclid_gcd_core.sv]
// top level of the gcd core: sequencer, datapath and result register
// depends on egcd_pkg, egcd_ctrl, egcd_datapath and euclid_gcd_core_assert.svh
//
// Returns gcd(|first_value|, |second_value|) for two signed operands, with the
// most negative value taken as magnitude 2^(DATA_WIDTH-1) and gcd(0, 0) = 0.
// One item is worked at a time with a binary gcd loop on a single shared
// subtract/shift unit: each cycle either halves even operands or subtracts the
// smaller odd one from the larger, so the time an item takes is set by the
// operand bit patterns and is shortest when an operand is zero.
// The operand port is not ready while an item is in the loop. The result sits
// in an output register, so the next item can be taken while it waits.
`include "euclid_gcd_core_assert.svh"
module euclid_gcd_core
	import egcd_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         op_valid,
	output logic                         op_ready,
	input  logic signed [DATA_WIDTH-1:0] first_value,
	input  logic signed [DATA_WIDTH-1:0] second_value,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic        [DATA_WIDTH-1:0] divisor
);

	egcd_cmd_t             cmd;
	egcd_stat_t            stat;
	logic [DATA_WIDTH-1:0] result;
	logic [DATA_WIDTH-1:0] divisor_q;
	logic                  res_valid_q;
	logic                  slot_free;

	assign slot_free = !res_valid_q || res_ready;

	egcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.slot_free (slot_free),
		.stat      (stat),
		.cmd       (cmd)
	);

	egcd_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.first_value  (first_value),
		.second_value (second_value),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			divisor_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign divisor   = divisor_q;

	// busy after an operand transfer
	`EGCD_ASSERT(a_busy_after_load, (op_valid && op_ready) |=> !op_ready, "ready after load")
	// a result only enters a free output register
	`EGCD_ASSERT_NEVER(a_no_overwrite, cmd.finish && res_valid_q && !res_ready, "result lost")
	// gcd of magnitudes never exceeds half the range
	`EGCD_ASSERT_NEVER(a_range, res_valid_q && divisor_q[DATA_WIDTH-1] && (divisor_q[DATA_WIDTH-2:0] != '0), "divisor out of range")

endmodule
